FILE: sv/mlfq_pkg.sv
// Package: shared types and constants of the feedback queue scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;
    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_AGE      = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    localparam logic [2:0] REG_QTOP = 3'd0;
    localparam logic [2:0] REG_QMID = 3'd1;
    localparam logic [2:0] REG_PMID = 3'd2;
    localparam logic [2:0] REG_PBOT = 3'd3;
    localparam logic [2:0] REG_IVAL = 3'd4;

    typedef struct packed {
        logic [7:0]  pid;
        logic [15:0] burst;
        logic [15:0] arrival;
        logic [15:0] wait_t;
    } t_rec;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  process_id;
        logic [1:0]  level;
        logic [15:0] burst_time;
        logic [15:0] arrival_time;
        logic [15:0] wait_start_time;
        logic [15:0] current_time;
        logic [15:0] promotion_count;
    } t_in;

    typedef struct packed {
        logic        found;
        logic        status;
        logic [7:0]  out_process_id;
        logic [1:0]  out_level;
        logic [15:0] out_burst_time;
        logic [15:0] out_arrival_time;
        logic [15:0] out_wait_start;
        logic [7:0]  quantum;
        logic        run_to_completion;
        logic [15:0] head_arrival_time;
        logic        all_empty;
    } t_out;

    typedef struct packed {
        logic [2:0]  idx;
        logic [15:0] data;
    } t_cfg;

    // Datapath commands from the controller.
    typedef enum logic [3:0] {
        C_NONE   = 4'd0,
        C_LOAD   = 4'd1,   // capture input item
        C_INS    = 4'd2,   // start insert decision
        C_SCAN   = 4'd3,   // read level-3 entry at scan index
        C_SCMP   = 4'd4,   // compare read entry, advance or stop
        C_SHRD   = 4'd5,   // read entry below shift index
        C_SHWR   = 4'd6,   // write it one place down
        C_PLACE  = 4'd7,   // write new record at position
        C_DISP   = 4'd8,   // read head for dispatch
        C_DPOP   = 4'd9,   // pop and latch result
        C_AGINIT = 4'd10,  // start aging of a level
        C_AGRD   = 4'd11,  // read head of aged level
        C_AGMV   = 4'd12,  // pop and push to one level
        C_HEAD   = 4'd13,  // read head for reporting
        C_FIN    = 4'd14   // latch head report into result
    } t_cmd;

    typedef struct packed {
        logic ins_simple;  // insert to a FIFO level
        logic ins_reject;
        logic scan_done;   // sorted scan found its place
        logic shift_done;
        logic age_done;    // all entries of the aged level visited
        logic age_bottom;  // aging level three now
    } t_sts;
endpackage

FILE: sv/mlfq_if.sv
// Interfaces: valid/ready channel carrying one item.
`timescale 1ns / 1ps
interface mlfq_in_if;
    import mlfq_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mlfq_out_if;
    import mlfq_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mlfq_cfg_if;
    import mlfq_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/mlfq_ctrl.sv
// Controller: sequences each operation over the datapath.
`timescale 1ns / 1ps
module mlfq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_op,
    input  mlfq_pkg::t_sts  i_sts,
    input  logic            i_out_free,
    output mlfq_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_done
);
    import mlfq_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_DEC  = 11'b00000000010,
        S_INS  = 11'b00000000100,
        S_SCAN = 11'b00000001000,
        S_SCMP = 11'b00000010000,
        S_SHRD = 11'b00000100000,
        S_SHWR = 11'b00001000000,
        S_DISP = 11'b00010000000,
        S_AGE  = 11'b00100000000,
        S_AGMV = 11'b01000000000,
        S_HEAD = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_fin, n_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fin   = 1'b0;
        o_cmd   = C_NONE;
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd   = C_LOAD;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_op)
                    OP_INSERT:   n_state = S_INS;
                    OP_DISPATCH: begin
                        o_cmd   = C_DISP;
                        n_state = S_DISP;
                    end
                    OP_AGE: begin
                        o_cmd   = C_AGINIT;
                        n_state = S_AGE;
                    end
                    default: begin
                        o_cmd   = C_HEAD;
                        n_state = S_HEAD;
                    end
                endcase
            end
            S_INS: begin
                if (i_sts.ins_reject || i_sts.ins_simple) begin
                    o_cmd   = C_PLACE;
                    n_state = S_HEAD;
                    n_fin   = 1'b1;
                end else begin
                    o_cmd   = C_INS;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd   = C_SCAN;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                o_cmd = C_SCMP;
                if (i_sts.scan_done) n_state = S_SHRD;
                else n_state = S_SCAN;
            end
            S_SHRD: begin
                if (i_sts.shift_done) begin
                    o_cmd   = C_PLACE;
                    n_state = S_HEAD;
                    n_fin   = 1'b1;
                end else begin
                    o_cmd   = C_SHRD;
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                o_cmd   = C_SHWR;
                n_state = S_SHRD;
            end
            S_DISP: begin
                o_cmd   = C_DPOP;
                n_state = S_HEAD;
                n_fin   = 1'b1;
            end
            S_AGE: begin
                if (i_sts.age_done) begin
                    if (i_sts.age_bottom) begin
                        n_state = S_HEAD;
                        n_fin   = 1'b1;
                    end else begin
                        o_cmd = C_AGINIT;
                    end
                end else begin
                    o_cmd   = C_AGRD;
                    n_state = S_AGMV;
                end
            end
            S_AGMV: begin
                o_cmd   = C_AGMV;
                n_state = S_AGE;
            end
            S_HEAD: begin
                // first visit issues the head read, second latches it
                if (r_fin) begin
                    o_cmd = C_HEAD;
                end else if (i_out_free) begin
                    o_cmd   = C_FIN;
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_done_from_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_HEAD) else $error("done outside head state");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> r_state == S_DEC) else $error("start not taken");
    a_head_read_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> !o_done) else $error("result before head read");
`endif
endmodule

FILE: sv/mlfq_dp.sv
// Datapath: queue memory, pointers, counts and result register.
`timescale 1ns / 1ps
module mlfq_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mlfq_pkg::t_cmd  i_cmd,
    input  mlfq_pkg::t_in   i_item,
    input  logic [7:0]      i_qtop,
    input  logic [7:0]      i_qmid,
    input  logic [15:0]     i_pmid,
    input  logic [15:0]     i_pbot,
    input  logic [15:0]     i_ival,
    output mlfq_pkg::t_sts  o_sts,
    output logic [1:0]      o_op,
    output mlfq_pkg::t_out  o_res
);
    import mlfq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = AW + 2;
    localparam int MD = 3 << AW;
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    t_rec mem [MD];
    t_rec r_rd;
    logic [AW-1:0] r_head [3];
    logic [CW-1:0] r_cnt [3];

    t_in  r_in;
    t_out r_res, n_res;
    logic [CW-1:0] r_pos;     // scan position / place position
    logic [CW-1:0] r_iter;    // aging iterations left / shift index
    logic [1:0]    r_alv;     // level being aged, 1 or 2 (zero based)
    logic          r_astart;
    logic [15:0]   r_nwait;
    logic [31:0]   w_prod;

    logic          we;
    logic [MW-1:0] wa, ra;
    t_rec          wd;
    logic          re;

    function automatic logic [MW-1:0] addr(input logic [1:0] lv, input logic [AW-1:0] h,
                                          input logic [CW-1:0] i);
        logic [CW:0] s;
        logic [AW-1:0] q;
        s = (CW+1)'(h) + (CW+1)'(i);
        if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
        q = s[AW-1:0];
        return {lv, q};
    endfunction

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] h);
        if ({1'b0, h} == (AW+1)'(QUEUE_DEPTH - 1)) return '0;
        return h + AW'(1);
    endfunction

    assign w_prod = i_ival * r_in.promotion_count;

    t_rec nrec;
    assign nrec = '{pid: r_in.process_id, burst: r_in.burst_time,
                    arrival: r_in.arrival_time, wait_t: r_in.wait_start_time};

    logic [1:0] ilv;
    assign ilv = (r_in.level == 2'd0) ? 2'd0 : r_in.level - 2'd1;

    logic [16:0] waited;
    logic [15:0] lim;
    logic        promo;
    assign waited = {1'b0, r_in.current_time} - {1'b0, r_rd.wait_t};
    assign lim    = (r_alv == 2'd1) ? i_pmid : i_pbot;
    assign promo  = !waited[16] && (waited[15:0] >= lim) && (r_cnt[r_alv - 2'd1] != FULL);

    logic [1:0] hlv;
    logic       hany;
    always_comb begin
        hany = 1'b1;
        priority if (r_cnt[0] != '0) hlv = 2'd0;
        else if (r_cnt[1] != '0) hlv = 2'd1;
        else if (r_cnt[2] != '0) hlv = 2'd2;
        else begin
            hlv  = 2'd0;
            hany = 1'b0;
        end
    end

    always_comb begin
        o_sts.ins_reject = (r_in.level == 2'd0) || (r_cnt[ilv] == FULL);
        o_sts.ins_simple = (r_in.level != 2'd3);
        o_sts.scan_done  = (r_pos == r_cnt[2]) || (r_rd.burst > r_in.burst_time);
        o_sts.shift_done = (r_iter == r_pos);
        o_sts.age_done   = !r_astart && (r_iter == '0);
        o_sts.age_bottom = (r_alv == 2'd2);
    end

    always_comb begin
        we = 1'b0; wa = '0; wd = r_rd; re = 1'b0; ra = '0;
        unique case (i_cmd)
            C_SCAN: begin re = 1'b1; ra = addr(2'd2, r_head[2], r_pos); end
            C_SHRD: begin re = 1'b1; ra = addr(2'd2, r_head[2], r_iter - CW'(1)); end
            C_SHWR: begin we = 1'b1; wa = addr(2'd2, r_head[2], r_iter); end
            C_PLACE: begin
                we = !o_sts.ins_reject;
                wd = nrec;
                if (r_in.level == 2'd3) wa = addr(2'd2, r_head[2], r_pos);
                else wa = addr(ilv, r_head[ilv], r_cnt[ilv]);
            end
            C_DISP: begin re = 1'b1; ra = addr(hlv, r_head[hlv], '0); end
            C_HEAD: begin re = 1'b1; ra = addr(hlv, r_head[hlv], '0); end
            C_AGRD: begin re = 1'b1; ra = addr(r_alv, r_head[r_alv], '0); end
            C_AGMV: begin
                we = 1'b1;
                if (promo) begin
                    wd.wait_t = r_nwait;
                    wa = addr(r_alv - 2'd1, r_head[r_alv - 2'd1], r_cnt[r_alv - 2'd1]);
                end else begin
                    wa = addr(r_alv, r_head[r_alv], r_cnt[r_alv]);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        if (re) r_rd <= mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == C_LOAD) r_in <= i_item;
        if (i_cmd == C_LOAD) r_nwait <= '0;
        else r_nwait <= (w_prod > 32'hFFFF) ? 16'hFFFF : w_prod[15:0];
    end

    always_comb begin
        n_res = r_res;
        unique case (i_cmd)
            C_LOAD: n_res = '0;
            C_PLACE: n_res.status = o_sts.ins_reject;
            C_DPOP: begin
                if (hany) begin
                    n_res.found            = 1'b1;
                    n_res.out_process_id   = r_rd.pid;
                    n_res.out_level        = hlv + 2'd1;
                    n_res.out_burst_time   = r_rd.burst;
                    n_res.out_arrival_time = r_rd.arrival;
                    n_res.out_wait_start   = r_rd.wait_t;
                    n_res.quantum = (hlv == 2'd0) ? i_qtop : ((hlv == 2'd1) ? i_qmid : 8'd0);
                    n_res.run_to_completion = (hlv == 2'd2);
                end
            end
            C_FIN: begin
                n_res.all_empty = !hany;
                n_res.head_arrival_time = hany ? r_rd.arrival : 16'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (!i_rst_n) begin
            for (int l = 0; l < 3; l++) begin
                r_head[l] <= '0;
                r_cnt[l]  <= '0;
            end
            r_pos    <= '0;
            r_iter   <= '0;
            r_alv    <= 2'd0;
            r_astart <= 1'b0;
        end else begin
            unique case (i_cmd)
                C_LOAD: begin r_alv <= 2'd0; r_astart <= 1'b0; end
                C_INS: begin
                    r_pos  <= '0;
                    r_iter <= r_cnt[2];
                end
                C_SCMP: if (!o_sts.scan_done) r_pos <= r_pos + CW'(1);
                C_SHWR: r_iter <= r_iter - CW'(1);
                C_PLACE: if (!o_sts.ins_reject) r_cnt[ilv] <= r_cnt[ilv] + CW'(1);
                C_DPOP: if (hany) begin
                    r_head[hlv] <= inc(r_head[hlv]);
                    r_cnt[hlv]  <= r_cnt[hlv] - CW'(1);
                end
                C_AGINIT: begin
                    r_alv    <= r_alv + 2'd1;
                    r_iter   <= r_cnt[r_alv + 2'd1];
                    r_astart <= 1'b0;
                end
                C_AGRD: r_iter <= r_iter - CW'(1);
                C_AGMV: begin
                    r_head[r_alv] <= inc(r_head[r_alv]);
                    if (promo) begin
                        r_cnt[r_alv] <= r_cnt[r_alv] - CW'(1);
                        r_cnt[r_alv - 2'd1] <= r_cnt[r_alv - 2'd1] + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_op  = r_in.opcode;
    assign o_res = r_res;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= FULL && r_cnt[1] <= FULL && r_cnt[2] <= FULL)
        else $error("count beyond depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == C_AGMV) |-> r_cnt[r_alv] != '0) else $error("aging an empty level");
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we && re)) else $error("read and write in one cycle");
`endif
endmodule

FILE: sv/multilevel_feedback_queue_scheduler_core.sv
// Top level of the three-level feedback queue scheduler.
//   channel   dir  handshake        payload
//   s_in      in   valid / ready    opcode and process record, times
//   m_out     out  valid / ready    dispatch result, head, empty flag
//   s_cfg     in   valid / ready    register index and data
// Each operation is sequenced over the single-port queue memory, one read or write a
// cycle; a sorted insert into level three scans and shifts its entries, and an age
// visits every entry of levels two and three.
// Reset clears heads, counts and control; the queue memory is not cleared.
// A held result blocks the next item; configuration is always taken.
`timescale 1ns / 1ps
module multilevel_feedback_queue_scheduler_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mlfq_in_if.sink    s_in,
    mlfq_out_if.source m_out,
    mlfq_cfg_if.sink   s_cfg
);
    import mlfq_pkg::*;

    logic [7:0]  r_qtop, r_qmid;
    logic [15:0] r_pmid, r_pbot, r_ival;
    logic        r_ovalid;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic        w_busy, w_done;
    logic [1:0]  w_op;
    t_out        w_res;

    // Hold the register file; writes must arrive only while idle, which the block itself does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qtop <= 8'd5;
            r_qmid <= 8'd8;
            r_pmid <= 16'd10;
            r_pbot <= 16'd20;
            r_ival <= 16'd1;
        end else if (s_cfg.valid) begin
            unique case (s_cfg.data.idx)
                REG_QTOP: r_qtop <= s_cfg.data.data[7:0];
                REG_QMID: r_qmid <= s_cfg.data.data[7:0];
                REG_PMID: r_pmid <= s_cfg.data.data;
                REG_PBOT: r_pbot <= s_cfg.data.data;
                REG_IVAL: r_ival <= s_cfg.data.data;
                default: ;
            endcase
        end
    end
    assign s_cfg.ready = 1'b1;

    // Accept an item only when idle and the result slot is free.
    assign s_in.ready = !w_busy && !r_ovalid;

    mlfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_in.valid && s_in.ready),
        .i_op       (w_op),
        .i_sts      (w_sts),
        .i_out_free (!r_ovalid),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy),
        .o_done     (w_done)
    );

    mlfq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (s_in.data),
        .i_qtop  (r_qtop),
        .i_qmid  (r_qmid),
        .i_pmid  (r_pmid),
        .i_pbot  (r_pbot),
        .i_ival  (r_ival),
        .o_sts   (w_sts),
        .o_op    (w_op),
        .o_res   (w_res)
    );

    // Raise valid once the result register is loaded; drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_done) r_ovalid <= 1'b1;
        else if (m_out.ready) r_ovalid <= 1'b0;
    end

    assign m_out.valid = r_ovalid;
    assign m_out.data  = w_res;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_in.ready) else $error("item taken while busy");
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !r_ovalid) else $error("result overwritten");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> $stable(m_out.data))
        else $error("result changed while held");
`endif
endmodule
